// ----- hw/rtl/fm_score_and_sgd_update_top_assert.svh -----
// assertion macros for the factorization machine engine checker
`ifndef FM_SCORE_AND_SGD_UPDATE_TOP_ASSERT_SVH
`define FM_SCORE_AND_SGD_UPDATE_TOP_ASSERT_SVH

// same-cycle implication, off while reset is high
`define FMSU_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off while reset is high
`define FMSU_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// condition that must hold in the cycle after a reset edge
`define FMSU_ASSERT_RST(lbl, cons, msg) \
   lbl: assert property (@(posedge clock) reset |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/fmsu_pkg.sv -----
// shared types, codes and saturation helpers of the factorization machine engine
package fmsu_pkg;

   typedef enum logic [2:0] {
      ACT_WLIN   = 3'd0,
      ACT_WLAT   = 3'd1,
      ACT_WBIAS  = 3'd2,
      ACT_SCORE  = 3'd3,
      ACT_UPDATE = 3'd4
   } act_type;

   localparam logic [1:0] CSR_FEAT_LIM = 2'd0;
   localparam logic [1:0] CSR_LATENT_K = 2'd1;
   localparam logic [1:0] CSR_LRATE    = 2'd2;
   localparam logic [1:0] CSR_LAMBDA   = 2'd3;

   localparam logic [12:0] RST_FEAT_LIM = 13'd4096;
   localparam logic [3:0]  RST_LATENT_K = 4'd8;
   localparam logic [16:0] RST_LRATE    = 17'd1311;
   localparam logic [16:0] RST_LAMBDA   = 17'd1;

   localparam logic signed [63:0] S48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
   localparam logic signed [63:0] S48_MIN = 64'shFFFF_8000_0000_0000;
   localparam logic signed [63:0] S32_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [63:0] S32_MIN = 64'shFFFF_FFFF_8000_0000;

   typedef struct packed {
      logic [12:0] feat_limit;
      logic [3:0]  latent_k;
      logic [16:0] step_size;
      logic [16:0] l2_weight;
   } cfg_type;

   typedef struct packed {
      act_type            act;
      logic [15:0]        feature_id;
      logic [2:0]         latent_dim;
      logic signed [31:0] value;
      logic [30:0]        row_scale;
      logic signed [31:0] loss_grad;
      logic               last;
      logic               feat_ok;
      logic               wr_ok;
   } item_type;

   function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
      logic signed [47:0] r;
      if (v > S48_MAX) r = S48_MAX[47:0];
      else if (v < S48_MIN) r = S48_MIN[47:0];
      else r = v[47:0];
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > S32_MAX) r = S32_MAX[31:0];
      else if (v < S32_MIN) r = S32_MIN[31:0];
      else r = v[31:0];
      return r;
   endfunction

endpackage

// ----- hw/rtl/fmsu_front.sv -----
// front end: request intake, classification, csr file and two-entry queue
module fmsu_front import fmsu_pkg::*; #(
   parameter int FEAT_DEPTH = 4096,
   parameter int MAX_K      = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_action,
   input  logic [15:0]        req_feature_id,
   input  logic [2:0]         req_latent_dim,
   input  logic signed [31:0] req_value,
   input  logic [30:0]        req_row_scale,
   input  logic signed [31:0] req_loss_grad,
   input  logic               req_last,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready,
   output cfg_type            cfg,
   output item_type           head,
   output logic               head_valid,
   input  logic               pop
);

   cfg_type     cfg_ff, cfg_in;
   item_type    q_ff [2];
   item_type    q_in [2];
   logic        wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        push, known, feat_in_range, dim_ok;
   item_type    new_item;

   assign pready     = 1'b1;
   assign cfg        = cfg_ff;
   assign busy       = (cnt_ff == 2'd2);
   assign head       = q_ff[rp_ff];
   assign head_valid = (cnt_ff != 2'd0);

   always_comb begin
      case (paddr[3:2])
         CSR_FEAT_LIM: prdata = 32'(cfg_ff.feat_limit);
         CSR_LATENT_K: prdata = 32'(cfg_ff.latent_k);
         CSR_LRATE:    prdata = 32'(cfg_ff.step_size);
         CSR_LAMBDA:   prdata = 32'(cfg_ff.l2_weight);
         default:      prdata = 32'd0;
      endcase
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite) begin
         case (paddr[3:2])
            CSR_FEAT_LIM: cfg_in.feat_limit = pwdata[12:0];
            CSR_LATENT_K: cfg_in.latent_k   = pwdata[3:0];
            CSR_LRATE:    cfg_in.step_size  = pwdata[16:0];
            CSR_LAMBDA:   cfg_in.l2_weight  = pwdata[16:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   // unused action codes are dropped here and never reach the back end
   assign known         = (req_action <= 3'(ACT_UPDATE));
   assign feat_in_range = ({1'b0, req_feature_id} < 17'(FEAT_DEPTH));
   assign dim_ok        = (7'(req_latent_dim) < 7'(MAX_K));

   always_comb begin
      new_item.act        = act_type'(req_action);
      new_item.feature_id = req_feature_id;
      new_item.latent_dim = req_latent_dim;
      new_item.value      = req_value;
      new_item.row_scale  = req_row_scale;
      new_item.loss_grad  = req_loss_grad;
      new_item.last       = req_last;
      new_item.feat_ok    = feat_in_range && (req_feature_id < {3'b000, cfg_ff.feat_limit});
      new_item.wr_ok      = feat_in_range &&
                            ((req_action != 3'(ACT_WLAT)) || dim_ok);
   end

   assign push = start && !busy && known;

   always_comb begin
      q_in[0] = q_ff[0];
      q_in[1] = q_ff[1];
      wp_in   = wp_ff;
      rp_in   = rp_ff;
      if (push) begin
         q_in[wp_ff] = new_item;
         wp_in       = !wp_ff;
      end
      if (pop) rp_in = !rp_ff;
      cnt_in = 2'(cnt_ff + {1'b0, push} - {1'b0, pop});
   end

   always_ff @(posedge clock) begin
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
      if (reset) begin
         cfg_ff.feat_limit <= RST_FEAT_LIM;
         cfg_ff.latent_k   <= RST_LATENT_K;
         cfg_ff.step_size  <= RST_LRATE;
         cfg_ff.l2_weight  <= RST_LAMBDA;
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         cfg_ff <= cfg_in;
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ----- hw/rtl/fmsu_mul.sv -----
// shared q16 multiplier: 48 x 32 magnitude product in two 24 x 32 halves
module fmsu_mul import fmsu_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               go,
   input  logic signed [47:0] a,
   input  logic signed [31:0] b,
   output logic               done,
   output logic signed [63:0] q
);

   logic [47:0] ma;
   logic [31:0] mb;
   logic [55:0] plo_ff, plo_in;
   logic [23:0] mahi_ff;
   logic [31:0] mb_ff;
   logic        neg1_ff, neg2_ff;
   logic        v1_ff, v2_ff;
   logic [55:0] phi;
   logic [79:0] full;
   logic [63:0] mag_ff, mag_in;

   assign ma     = a[47] ? 48'(-a) : 48'(a);
   assign mb     = b[31] ? 32'(-b) : 32'(b);
   assign plo_in = 56'(ma[23:0]) * 56'(mb);

   assign phi    = 56'(mahi_ff) * 56'(mb_ff);
   assign full   = 80'(plo_ff) + {phi, 24'd0};
   // truncation toward zero on the magnitude
   assign mag_in = full[79:16];

   assign done = v2_ff;
   assign q    = neg2_ff ? -$signed(mag_ff) : $signed(mag_ff);

   always_ff @(posedge clock) begin
      plo_ff  <= plo_in;
      mahi_ff <= ma[47:24];
      mb_ff   <= mb;
      neg1_ff <= a[47] ^ b[31];
      neg2_ff <= neg1_ff;
      mag_ff  <= mag_in;
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= go;
         v2_ff <= v1_ff;
      end
   end

endmodule

// ----- hw/rtl/fmsu_back.sv -----
// back end: weight memories, row sums and the scoring / sgd sequencer
module fmsu_back import fmsu_pkg::*; #(
   parameter int FEAT_DEPTH = 4096,
   parameter int MAX_K      = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  item_type           head,
   input  logic               head_valid,
   output logic               pop,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_score,
   output logic               rsp_saturated
);

   localparam int FIDW = $clog2(FEAT_DEPTH);
   localparam int LAW  = $clog2(FEAT_DEPTH * MAX_K);
   localparam int DIW  = (MAX_K > 1) ? $clog2(MAX_K) : 1;
   localparam int DCW  = $clog2(MAX_K + 1);
   localparam int KCW  = (DCW > 4) ? DCW : 4;

   typedef enum logic [15:0] {
      ST_IDLE = 16'h0001,
      ST_DEC  = 16'h0002,
      ST_X    = 16'h0004,
      ST_LIN  = 16'h0008,
      ST_RDV  = 16'h0010,
      ST_VX   = 16'h0020,
      ST_PAIR = 16'h0040,
      ST_PG   = 16'h0080,
      ST_WL   = 16'h0100,
      ST_WG   = 16'h0200,
      ST_UVX  = 16'h0400,
      ST_UVL  = 16'h0800,
      ST_UEP  = 16'h1000,
      ST_UVG  = 16'h2000,
      ST_FIN  = 16'h4000,
      ST_BIAS = 16'h8000
   } state_type;

   state_type          state_ff, state_in;
   logic               issued_ff, issued_in;
   item_type           cur_ff, cur_in;
   logic signed [31:0] x_ff, x_in, vx_ff, vx_in, pgv_ff, pgv_in;
   logic signed [47:0] g_ff, g_in, err_ff, err_in, vl_ff, vl_in, lg_ff, lg_in;
   logic [DCW-1:0]     d_ff, d_in;
   logic signed [47:0] sum_ff [MAX_K];
   logic signed [47:0] sum_in [MAX_K];
   logic signed [47:0] lt_ff, lt_in, pt_ff, pt_in;
   logic signed [31:0] bias_ff, bias_in;
   logic               row_open_ff, row_open_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_score_ff, rsp_score_in;
   logic               rsp_sat_ff, rsp_sat_in;

   logic signed [31:0] lin_mem_ff [FEAT_DEPTH];
   logic signed [31:0] lat_mem_ff [FEAT_DEPTH * MAX_K];
   logic signed [31:0] lin_rd_ff, lat_rd_ff;
   logic               lin_we, lin_re, lat_we, lat_re;
   logic signed [31:0] lin_wd, lat_wd;
   logic [FIDW-1:0]    fid_idx;
   logic [LAW-1:0]     lat_addr;
   logic               lat_wr_sel;

   logic               mul_go, mul_done, mul_state;
   logic signed [47:0] mul_a;
   logic signed [31:0] mul_b;
   logic signed [63:0] q;

   logic [KCW-1:0]     lk;
   logic [DCW-1:0]     k_eff, d_next;
   logic [DIW-1:0]     di;
   logic signed [63:0] total;
   logic signed [31:0] score;
   logic               is_score;

   assign lk       = KCW'(cfg.latent_k);
   assign k_eff    = (lk > KCW'(MAX_K)) ? DCW'(MAX_K) : DCW'(lk);
   assign di       = d_ff[DIW-1:0];
   assign d_next   = d_ff + DCW'(1);
   assign fid_idx  = cur_ff.feature_id[FIDW-1:0];
   assign is_score = (cur_ff.act == ACT_SCORE);
   assign lat_addr = LAW'(fid_idx) * LAW'(MAX_K) +
                     (lat_wr_sel ? LAW'(cur_ff.latent_dim) : LAW'(di));
   assign total    = 64'(bias_ff) + 64'(lt_ff) + 64'(pt_ff);
   assign score    = sat32(total);

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_score     = rsp_score_ff;
   assign rsp_saturated = rsp_sat_ff;

   // operand routing for the shared multiplier
   always_comb begin
      mul_state = 1'b1;
      mul_a     = 48'sd0;
      mul_b     = 32'sd0;
      case (state_ff)
         ST_X:    begin mul_a = 48'(cur_ff.value); mul_b = $signed({1'b0, cur_ff.row_scale}); end
         ST_LIN:  begin mul_a = 48'(x_ff); mul_b = lin_rd_ff; end
         ST_VX:   begin mul_a = 48'(lat_rd_ff); mul_b = x_ff; end
         ST_UVX:  begin mul_a = 48'(lat_rd_ff); mul_b = x_ff; end
         ST_PAIR: begin mul_a = sum_ff[di]; mul_b = vx_ff; end
         ST_PG:   begin mul_a = 48'(cur_ff.loss_grad); mul_b = x_ff; end
         ST_WL:   begin mul_a = 48'(lin_rd_ff); mul_b = $signed({15'd0, cfg.l2_weight}); end
         ST_WG:   begin mul_a = g_ff; mul_b = $signed({15'd0, cfg.step_size}); end
         ST_UVL:  begin mul_a = 48'(lat_rd_ff); mul_b = $signed({15'd0, cfg.l2_weight}); end
         ST_UEP:  begin mul_a = err_ff; mul_b = pgv_ff; end
         ST_UVG:  begin mul_a = lg_ff; mul_b = $signed({15'd0, cfg.step_size}); end
         ST_BIAS: begin mul_a = 48'(cur_ff.loss_grad); mul_b = $signed({15'd0, cfg.step_size}); end
         default: mul_state = 1'b0;
      endcase
   end

   assign mul_go = mul_state && !issued_ff;

   fmsu_mul u_mul (
      .clock (clock),
      .reset (reset),
      .go    (mul_go),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .q     (q)
   );

   always_comb begin
      state_in     = state_ff;
      issued_in    = mul_go ? 1'b1 : (mul_done ? 1'b0 : issued_ff);
      cur_in       = cur_ff;
      x_in         = x_ff;
      vx_in        = vx_ff;
      pgv_in       = pgv_ff;
      g_in         = g_ff;
      err_in       = err_ff;
      vl_in        = vl_ff;
      lg_in        = lg_ff;
      d_in         = d_ff;
      for (int i = 0; i < MAX_K; i++) sum_in[i] = sum_ff[i];
      lt_in        = lt_ff;
      pt_in        = pt_ff;
      bias_in      = bias_ff;
      row_open_in  = row_open_ff;
      rsp_valid_in = 1'b0;
      rsp_score_in = rsp_score_ff;
      rsp_sat_in   = rsp_sat_ff;
      pop          = 1'b0;
      lin_we       = 1'b0;
      lin_re       = 1'b0;
      lat_we       = 1'b0;
      lat_re       = 1'b0;
      lin_wd       = cur_ff.value;
      lat_wd       = cur_ff.value;
      lat_wr_sel   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               pop      = 1'b1;
               cur_in   = head;
               state_in = ST_DEC;
            end
         end
         ST_DEC: begin
            state_in = ST_IDLE;
            case (cur_ff.act)
               ACT_WLIN: lin_we = cur_ff.wr_ok;
               ACT_WLAT: begin
                  lat_we     = cur_ff.wr_ok;
                  lat_wr_sel = 1'b1;
               end
               ACT_WBIAS: bias_in = cur_ff.value;
               ACT_SCORE: begin
                  // first feature of a row clears the running sums
                  if (!row_open_ff) begin
                     for (int i = 0; i < MAX_K; i++) sum_in[i] = 48'sd0;
                     lt_in       = 48'sd0;
                     pt_in       = 48'sd0;
                     row_open_in = 1'b1;
                  end
                  lin_re   = cur_ff.feat_ok;
                  state_in = cur_ff.feat_ok ? ST_X : ST_FIN;
               end
               ACT_UPDATE: begin
                  lin_re   = cur_ff.feat_ok;
                  state_in = cur_ff.feat_ok ? ST_X : ST_FIN;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_X: begin
            if (mul_done) begin
               x_in     = sat32(q);
               state_in = is_score ? ST_LIN : ST_PG;
            end
         end
         ST_LIN: begin
            if (mul_done) begin
               lt_in    = sat48(64'(lt_ff) + q);
               d_in     = '0;
               state_in = (k_eff == '0) ? ST_FIN : ST_RDV;
            end
         end
         ST_RDV: begin
            lat_re   = 1'b1;
            state_in = is_score ? ST_VX : ST_UVX;
         end
         ST_VX: begin
            if (mul_done) begin
               vx_in    = sat32(q);
               state_in = ST_PAIR;
            end
         end
         ST_PAIR: begin
            if (mul_done) begin
               pt_in      = sat48(64'(pt_ff) + 64'(sat48(q)));
               sum_in[di] = sat48(64'(sum_ff[di]) + 64'(vx_ff));
               d_in       = d_next;
               state_in   = (d_next < k_eff) ? ST_RDV : ST_FIN;
            end
         end
         ST_PG: begin
            if (mul_done) begin
               pgv_in   = sat32(q);
               state_in = ST_WL;
            end
         end
         ST_WL: begin
            if (mul_done) begin
               g_in     = sat48(q + 64'(pgv_ff));
               state_in = ST_WG;
            end
         end
         ST_WG: begin
            if (mul_done) begin
               lin_we   = 1'b1;
               lin_wd   = sat32(64'(lin_rd_ff) - q);
               d_in     = '0;
               state_in = (k_eff == '0) ? ST_FIN : ST_RDV;
            end
         end
         ST_UVX: begin
            if (mul_done) begin
               err_in   = sat48(64'(sum_ff[di]) - 64'(sat32(q)));
               state_in = ST_UVL;
            end
         end
         ST_UVL: begin
            if (mul_done) begin
               vl_in    = q[47:0];
               state_in = ST_UEP;
            end
         end
         ST_UEP: begin
            if (mul_done) begin
               lg_in    = sat48(64'(vl_ff) + 64'(sat48(q)));
               state_in = ST_UVG;
            end
         end
         ST_UVG: begin
            if (mul_done) begin
               lat_we   = 1'b1;
               lat_wd   = sat32(64'(lat_rd_ff) - q);
               d_in     = d_next;
               state_in = (d_next < k_eff) ? ST_RDV : ST_FIN;
            end
         end
         ST_FIN: begin
            state_in = ST_IDLE;
            if (is_score && cur_ff.last) begin
               rsp_valid_in = 1'b1;
               rsp_score_in = score;
               rsp_sat_in   = (64'(score) != total);
               row_open_in  = 1'b0;
            end else if (!is_score && cur_ff.last) begin
               state_in = ST_BIAS;
            end
         end
         ST_BIAS: begin
            if (mul_done) begin
               bias_in  = sat32(64'(bias_ff) - q);
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (lin_we) lin_mem_ff[fid_idx] <= lin_wd;
      if (lin_re) lin_rd_ff <= lin_mem_ff[fid_idx];
   end

   always_ff @(posedge clock) begin
      if (lat_we) lat_mem_ff[lat_addr] <= lat_wd;
      if (lat_re) lat_rd_ff <= lat_mem_ff[lat_addr];
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      x_ff         <= x_in;
      vx_ff        <= vx_in;
      pgv_ff       <= pgv_in;
      g_ff         <= g_in;
      err_ff       <= err_in;
      vl_ff        <= vl_in;
      lg_ff        <= lg_in;
      d_ff         <= d_in;
      rsp_score_ff <= rsp_score_in;
      rsp_sat_ff   <= rsp_sat_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         issued_ff    <= 1'b0;
         for (int i = 0; i < MAX_K; i++) sum_ff[i] <= 48'sd0;
         lt_ff        <= 48'sd0;
         pt_ff        <= 48'sd0;
         bias_ff      <= 32'sd0;
         row_open_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         for (int i = 0; i < MAX_K; i++) sum_ff[i] <= sum_in[i];
         lt_ff        <= lt_in;
         pt_ff        <= pt_in;
         bias_ff      <= bias_in;
         row_open_ff  <= row_open_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- hw/rtl/fm_score_and_sgd_update_top.sv -----
// top level of the factorization machine scoring and sgd engine
//
// requests enter on start/req_* and are taken when start is high and busy low;
// busy rises only while the two-entry request queue is full.
// weight writes (linear, latent, bias) are made in the decode state that follows the pop.
// in the back end a score or update request loops over latent dimensions 0 up to
// k-1, where k is latent_k clipped to MAX_K; an update adds a bias step on the row's
// last request, and a skipped feature goes straight to the finish state.
// the single shared multiplier works on one product at a time.
// the last score request of a row gives one result: rsp_valid pulses for one
// cycle with rsp_score and rsp_saturated; the receiver cannot stall it.
// registers sit on an apb port at byte offsets 0, 4, 8, 12 (feature limit, latent_k,
// step size, l2 weight), written by the user only while the engine idles (not enforced).
// synchronous reset clears the queue, row sums, bias and open-row flag and resets the
// registers to defaults; weight memories keep their contents and must be written first.
module fm_score_and_sgd_update_top import fmsu_pkg::*; #(
   parameter int FEAT_DEPTH = 4096,
   parameter int MAX_K      = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_action,
   input  logic [15:0]        req_feature_id,
   input  logic [2:0]         req_latent_dim,
   input  logic signed [31:0] req_value,
   input  logic [30:0]        req_row_scale,
   input  logic signed [31:0] req_loss_grad,
   input  logic               req_last,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_score,
   output logic               rsp_saturated,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   cfg_type  cfg;
   item_type head;
   logic     head_valid;
   logic     pop;

   fmsu_front #(.FEAT_DEPTH(FEAT_DEPTH), .MAX_K(MAX_K)) u_front (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_feature_id (req_feature_id),
      .req_latent_dim (req_latent_dim),
      .req_value      (req_value),
      .req_row_scale  (req_row_scale),
      .req_loss_grad  (req_loss_grad),
      .req_last       (req_last),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .cfg            (cfg),
      .head           (head),
      .head_valid     (head_valid),
      .pop            (pop)
   );

   fmsu_back #(.FEAT_DEPTH(FEAT_DEPTH), .MAX_K(MAX_K)) u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .head          (head),
      .head_valid    (head_valid),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_score     (rsp_score),
      .rsp_saturated (rsp_saturated)
   );

endmodule

// ----- hw/rtl/fmsu_checker.sv -----
// port-level checker for the factorization machine engine, bound to the top
`include "fm_score_and_sgd_update_top_assert.svh"

module fmsu_checker (
   input logic        clock,
   input logic        reset,
   input logic        busy,
   input logic        rsp_valid,
   input logic [31:0] rsp_score,
   input logic        rsp_saturated
);

   logic on_rail;

   assign on_rail = (rsp_score == 32'h7FFF_FFFF) || (rsp_score == 32'h8000_0000);

   `FMSU_ASSERT_NEXT(a_rsp_single, rsp_valid, !rsp_valid, "back-to-back results")
   `FMSU_ASSERT_IMP(a_sat_rail, rsp_valid && rsp_saturated, on_rail, "saturated score off rails")
   `FMSU_ASSERT_RST(a_reset_quiet, !rsp_valid && !busy, "not quiet after reset")

endmodule

bind fm_score_and_sgd_update_top fmsu_checker u_fmsu_checker (.*);
